### rtl/khist_pkg.sv
// Shared types, codes and helper functions for the keyed event histogram table.
package khist_pkg;

  // Kind codes carried by an input item.
  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // Status codes carried by a result item.
  localparam logic [2:0] STAT_FILTERED = 3'd0;
  localparam logic [2:0] STAT_COUNTED  = 3'd1;
  localparam logic [2:0] STAT_NEW      = 3'd2;
  localparam logic [2:0] STAT_OVERFLOW = 3'd3;
  localparam logic [2:0] STAT_READ     = 3'd4;
  localparam logic [2:0] STAT_CLEARED  = 3'd5;

  localparam logic [3:0]  WANTED_ORDER_RESET = 4'd9;
  localparam logic [31:0] COUNT_MAX          = 32'hFFFF_FFFF;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  order;
    logic [63:0] site_addr;
    logic [63:0] task_name_lo;
    logic [63:0] task_name_hi;
    logic [5:0]  entry_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  slot_index;
    logic        entry_valid;
    logic [63:0] entry_site;
    logic [63:0] entry_name_lo;
    logic [63:0] entry_name_hi;
    logic [31:0] entry_count;
    logic [31:0] total_count;
    logic [6:0]  used_entries;
    logic [31:0] overflow_count;
  } out_item_t;

  // Operation decided by the front for each item.
  typedef enum logic [1:0] {
    OP_FILTER,
    OP_EVENT,
    OP_READ,
    OP_CLEAR
  } op_t;

  // One queued work item, with the name already masked.
  typedef struct packed {
    op_t         op;
    logic [63:0] site_addr;
    logic [63:0] name_lo;
    logic [63:0] name_hi;
    logic [5:0]  entry_index;
  } q_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_READ
  } back_state_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == COUNT_MAX) ? v : v + 32'd1;
  endfunction

endpackage

### rtl/keyed_event_histogram_table.sv
// Top level of the keyed event histogram table.
//
// This block counts allocation events per (call site, task name) key in a table of
// TABLE_ENTRIES entries, and answers read and clear requests, one result per input
// transfer. A front stage filters events against the wanted_order register and masks the
// name to NAME_BYTES bytes; a two-deep queue then hands each item to a back stage that
// owns the entry memory and the counters, so the input can keep taking transfers while a
// finished result waits on out_stall. The back stage works on one item at a time. Filtered
// events, clears, reads of an entry not in use and events into an empty table are finished
// in BK_IDLE as the item is taken; a read of an entry in use goes on through BK_READ. A
// counted event searches the entries in use in BK_SCAN through the single read port of
// the entry memory, one entry per cycle, until a hit or the last entry in use. The queue
// registers each item before the back stage takes it. Entries are appended in order and
// a clear resets only the fill count and the counters, not the entries, so no clearing
// pass is needed after reset or clear. All counters saturate at their maximum value.
// wanted_order may be written only while the block is idle.
module keyed_event_histogram_table #(
  parameter int TABLE_ENTRIES = 64,
  parameter int NAME_BYTES    = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [3:0]           cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  khist_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output khist_pkg::out_item_t out_data
);
  import khist_pkg::*;

  q_status_t q_stat;
  q_item_t   push_item;
  q_item_t   head_item;
  logic      q_push;
  logic      q_pop;

  // Front: filter register, classification and name masking.
  khist_front #(
    .NAME_BYTES(NAME_BYTES)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .q_stat      (q_stat),
    .q_push      (q_push),
    .q_item      (push_item)
  );

  // Queue that decouples the input side from the table engine.
  khist_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_item (push_item),
    .pop     (q_pop),
    .rd_item (head_item),
    .stat    (q_stat)
  );

  // Back: entry memory, search, counters and result register.
  khist_back #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .NAME_BYTES   (NAME_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head_item),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### rtl/khist_front.sv
// Front end: holds the order filter register, classifies and masks incoming items.
module khist_front #(
  parameter int NAME_BYTES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [3:0]          cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  khist_pkg::in_item_t in_data,
  input  khist_pkg::q_status_t q_stat,
  output logic                q_push,
  output khist_pkg::q_item_t  q_item
);
  import khist_pkg::*;

  localparam logic [128:0] ONE_W     = 129'd1;
  localparam logic [127:0] NAME_MASK = 128'((ONE_W << (8 * NAME_BYTES)) - ONE_W);

  logic [3:0]   wanted_order_r;
  logic [3:0]   wanted_order_nxt;
  logic [127:0] name_masked;
  op_t          op;

  always_comb begin
    wanted_order_nxt = cfg_wr_en ? cfg_wr_data : wanted_order_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_order_r <= WANTED_ORDER_RESET;
    end else begin
      wanted_order_r <= wanted_order_nxt;
    end
  end

  always_comb begin
    unique case (in_data.kind)
      KIND_ALLOC: op = (in_data.order == wanted_order_r) ? OP_EVENT : OP_FILTER;
      KIND_READ:  op = OP_READ;
      KIND_CLEAR: op = OP_CLEAR;
      default:    op = OP_FILTER;
    endcase
  end

  assign name_masked = {in_data.task_name_hi, in_data.task_name_lo} & NAME_MASK;

  assign in_stall = q_stat.full;
  assign q_push   = in_valid && !q_stat.full;

  always_comb begin
    q_item.op          = op;
    q_item.site_addr   = in_data.site_addr;
    q_item.name_lo     = name_masked[63:0];
    q_item.name_hi     = name_masked[127:64];
    q_item.entry_index = in_data.entry_index;
  end

endmodule

### rtl/khist_fifo.sv
// Short queue of classified work items between the front and the back.
module khist_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  khist_pkg::q_item_t   wr_item,
  input  logic                 pop,
  output khist_pkg::q_item_t   rd_item,
  output khist_pkg::q_status_t stat
);
  import khist_pkg::*;

  q_item_t           slots_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QPTR_W:0]   fill_r;
  logic [QPTR_W:0]   fill_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + (QPTR_W + 1)'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - (QPTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= wr_item;
    end
  end

  assign rd_item    = slots_r[rd_ptr_r];
  assign stat.full  = (fill_r == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign stat.empty = (fill_r == '0);

endmodule

### rtl/khist_back.sv
// Back end: entry memory, sequential key search, counters and the result register.
module khist_back #(
  parameter int TABLE_ENTRIES = 64,
  parameter int NAME_BYTES    = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  khist_pkg::q_item_t   head,
  input  khist_pkg::q_status_t q_stat,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output khist_pkg::out_item_t out_data
);
  import khist_pkg::*;

  localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int NAME_W = 8 * NAME_BYTES;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

  typedef struct packed {
    logic [63:0]       site;
    logic [NAME_W-1:0] name;
    logic [31:0]       count;
  } entry_t;

  entry_t      mem [TABLE_ENTRIES];
  entry_t      rd_r;
  logic        mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [IDX_W-1:0] mem_raddr;
  entry_t      mem_wdata;

  back_state_t state_r;
  back_state_t state_nxt;
  q_item_t     cur_r;
  q_item_t     cur_nxt;
  logic [IDX_W-1:0] scan_r;
  logic [IDX_W-1:0] scan_nxt;
  logic [CNT_W-1:0] used_r;
  logic [CNT_W-1:0] used_nxt;
  logic [31:0] total_r;
  logic [31:0] total_nxt;
  logic [31:0] dropped_r;
  logic [31:0] dropped_nxt;
  logic        out_valid_r;
  logic        out_valid_nxt;
  out_item_t   out_r;
  out_item_t   out_nxt;
  out_item_t   res;
  logic        out_load;

  logic              out_free;
  logic              start;
  logic              head_in_use;
  logic              hit;
  logic              last;
  logic [NAME_W-1:0] head_name;
  logic [NAME_W-1:0] cur_name;
  logic [127:0]      rd_name_ext;
  logic [31:0]       rd_count_inc;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_r <= mem[mem_raddr];
  end

  assign out_free     = !out_valid_r || !out_stall;
  assign start        = (state_r == BK_IDLE) && !q_stat.empty && out_free;
  assign q_pop        = start;
  assign head_in_use  = 32'(head.entry_index) < 32'(used_r);
  assign head_name    = NAME_W'({head.name_hi, head.name_lo});
  assign cur_name     = NAME_W'({cur_r.name_hi, cur_r.name_lo});
  assign hit          = (rd_r.site == cur_r.site_addr) && (rd_r.name == cur_name);
  assign last         = (CNT_W'(scan_r) + CNT_W'(1)) == used_r;
  assign rd_name_ext  = 128'(rd_r.name);
  assign rd_count_inc = sat_inc(rd_r.count);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (start) begin
          if (head.op == OP_EVENT && used_r != '0) begin
            state_nxt = BK_SCAN;
          end else if (head.op == OP_READ && head_in_use) begin
            state_nxt = BK_READ;
          end
        end
      end
      BK_SCAN: begin
        if (hit || last) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_READ: state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Datapath, memory control and result.
  always_comb begin
    cur_nxt     = start ? head : cur_r;
    scan_nxt    = scan_r;
    used_nxt    = used_r;
    total_nxt   = total_r;
    dropped_nxt = dropped_r;
    mem_we      = 1'b0;
    mem_waddr   = scan_r;
    mem_raddr   = scan_r;
    mem_wdata   = '0;
    res         = '0;
    out_load    = 1'b0;

    unique case (state_r)
      BK_IDLE: begin
        if (start) begin
          unique case (head.op)
            OP_FILTER: begin
              out_load   = 1'b1;
              res.status = STAT_FILTERED;
            end
            OP_CLEAR: begin
              used_nxt    = '0;
              total_nxt   = '0;
              dropped_nxt = '0;
              out_load    = 1'b1;
              res.status  = STAT_CLEARED;
            end
            OP_READ: begin
              mem_raddr = IDX_W'(head.entry_index);
              if (!head_in_use) begin
                out_load       = 1'b1;
                res.status     = STAT_READ;
                res.slot_index = head.entry_index;
              end
            end
            OP_EVENT: begin
              total_nxt = sat_inc(total_r);
              if (used_r == '0) begin
                // Empty table: the key goes straight into the first entry.
                mem_we          = 1'b1;
                mem_waddr       = '0;
                mem_wdata.site  = head.site_addr;
                mem_wdata.name  = head_name;
                mem_wdata.count = 32'd1;
                used_nxt        = CNT_W'(1);
                out_load        = 1'b1;
                res.status        = STAT_NEW;
                res.entry_valid   = 1'b1;
                res.entry_site    = head.site_addr;
                res.entry_name_lo = head.name_lo;
                res.entry_name_hi = head.name_hi;
                res.entry_count   = 32'd1;
              end else begin
                scan_nxt  = '0;
                mem_raddr = '0;
              end
            end
            default: begin
              out_load = 1'b0;
            end
          endcase
        end
      end
      BK_SCAN: begin
        if (hit) begin
          mem_we          = 1'b1;
          mem_waddr       = scan_r;
          mem_wdata       = rd_r;
          mem_wdata.count = rd_count_inc;
          out_load        = 1'b1;
          res.status        = STAT_COUNTED;
          res.slot_index    = 6'(scan_r);
          res.entry_valid   = 1'b1;
          res.entry_site    = cur_r.site_addr;
          res.entry_name_lo = cur_r.name_lo;
          res.entry_name_hi = cur_r.name_hi;
          res.entry_count   = rd_count_inc;
        end else if (!last) begin
          scan_nxt  = scan_r + IDX_W'(1);
          mem_raddr = scan_r + IDX_W'(1);
        end else if (used_r < FULL_CNT) begin
          mem_we          = 1'b1;
          mem_waddr       = IDX_W'(used_r);
          mem_wdata.site  = cur_r.site_addr;
          mem_wdata.name  = cur_name;
          mem_wdata.count = 32'd1;
          used_nxt        = used_r + CNT_W'(1);
          out_load        = 1'b1;
          res.status        = STAT_NEW;
          res.slot_index    = 6'(used_r);
          res.entry_valid   = 1'b1;
          res.entry_site    = cur_r.site_addr;
          res.entry_name_lo = cur_r.name_lo;
          res.entry_name_hi = cur_r.name_hi;
          res.entry_count   = 32'd1;
        end else begin
          dropped_nxt = sat_inc(dropped_r);
          out_load    = 1'b1;
          res.status  = STAT_OVERFLOW;
        end
      end
      BK_READ: begin
        out_load          = 1'b1;
        res.status        = STAT_READ;
        res.slot_index    = cur_r.entry_index;
        res.entry_valid   = 1'b1;
        res.entry_site    = rd_r.site;
        res.entry_name_lo = rd_name_ext[63:0];
        res.entry_name_hi = rd_name_ext[127:64];
        res.entry_count   = rd_r.count;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase

    res.total_count    = total_nxt;
    res.used_entries   = 7'(used_nxt);
    res.overflow_count = dropped_nxt;

    out_valid_nxt = out_load || (out_valid_r && out_stall);
    out_nxt       = out_load ? res : out_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      used_r      <= '0;
      total_r     <= '0;
      dropped_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      total_r     <= total_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    scan_r <= scan_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### rtl/khist_checker.sv
// Port-level checker for the keyed event histogram table, with its bind statement.
module khist_checker #(
  parameter int TABLE_ENTRIES = 64
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_stall,
  input khist_pkg::out_item_t out_data
);
  import khist_pkg::*;

  // A result that is held back keeps its value until the transfer.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // A clear leaves every total at zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == STAT_CLEARED |->
      out_data.total_count == 32'd0 && out_data.used_entries == 7'd0 &&
      out_data.overflow_count == 32'd0)
    else $error("clear result shows nonzero totals");

  // A new entry is the last one in use and starts with a count of one.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == STAT_NEW |->
      out_data.entry_valid && out_data.entry_count == 32'd1 &&
      out_data.slot_index == 6'(out_data.used_entries - 7'd1))
    else $error("new entry result inconsistent with fill count");

  // Events are dropped only when the table is full.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == STAT_OVERFLOW |->
      !out_data.entry_valid && out_data.used_entries == 7'(TABLE_ENTRIES) &&
      out_data.overflow_count != 32'd0)
    else $error("overflow reported while table not full");

endmodule

bind keyed_event_histogram_table khist_checker #(
  .TABLE_ENTRIES(TABLE_ENTRIES)
) u_khist_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
